/* rtl/aes128_pkg.sv */
// AES-128 shared package: sizes, S-box, round helper functions.
// Used by every file of the block; depends on nothing.
package aes128_pkg;

  localparam int NumRounds  = 10;
  localparam int StoreDepth = 2 * (NumRounds + 1);
  localparam int SlotW      = 5;
  localparam int HalfW      = 64;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ENCRYPT = 1'b1;

  typedef logic [127:0] state_t;
  typedef logic [HalfW-1:0] half_t;
  typedef logic [SlotW-1:0] slot_t;

  // S-box
  function automatic logic [7:0] sbox(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i sits at bits [127-8i -: 8]
  function automatic logic [7:0] byte_of(input state_t s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // SubBytes + ShiftRows
  function automatic state_t sub_shift(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = sbox(byte_of(s, r + 4*((c + r) & 3)));
      end
    end
    return t;
  endfunction

  function automatic state_t mix_cols(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(s, 4*c);
      a1 = byte_of(s, 4*c+1);
      a2 = byte_of(s, 4*c+2);
      a3 = byte_of(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c)   -: 8] = a0 ^ al ^ gf_dbl(a0 ^ a1);
      t[127-8*(4*c+1) -: 8] = a1 ^ al ^ gf_dbl(a1 ^ a2);
      t[127-8*(4*c+2) -: 8] = a2 ^ al ^ gf_dbl(a2 ^ a3);
      t[127-8*(4*c+3) -: 8] = a3 ^ al ^ gf_dbl(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

/* rtl/aes128_if.sv */
// Valid/ready channel interfaces for the AES-128 block.
// Depends on aes128_pkg.
interface aes128_in_if;
  import aes128_pkg::*;
  logic  valid;
  logic  ready;
  logic  func;
  slot_t key_slot;
  half_t data_hi;
  half_t data_lo;
  modport source (output valid, func, key_slot, data_hi, data_lo, input ready);
  modport sink   (input valid, func, key_slot, data_hi, data_lo, output ready);
endinterface

interface aes128_out_if;
  import aes128_pkg::*;
  logic  valid;
  logic  ready;
  half_t cipher_hi;
  half_t cipher_lo;
  modport source (output valid, cipher_hi, cipher_lo, input ready);
  modport sink   (input valid, cipher_hi, cipher_lo, output ready);
endinterface

/* rtl/aes128_block_encrypt.sv */
// AES-128 encryption top level: key store, unrolled round pipeline, output.
// Depends on aes128_pkg, aes128_if, aes128_keyreg.
//
//  channel  dir  payload                               accepted when
//  in_      in   func, key_slot, data_hi, data_lo      in_.valid && in_.ready
//  out_     out  cipher_hi, cipher_lo                  out_.valid && out_.ready
//
// One encrypt word per cycle enters unless the pipeline is stalled; its ciphertext can
// be taken on out_ once it has passed the whitening stage and one stage per
// round, the last round stage being the output register.
// Load words write the key store and leave no result; a load waits until the
// pipeline is empty, so words in flight always see the keys of their own time.
// Reset (rst_n, synchronous) clears the stage valid bits only.
// A stall on out_ holds only the full stages next to the output; bubbles are squeezed out since
// a stage advances whenever the stage after it is empty or moving.
module aes128_block_encrypt
  import aes128_pkg::*;
(
  input logic clk,
  input logic rst_n,
  aes128_in_if.sink    in_,
  aes128_out_if.source out_
);

  state_t rkey [NumRounds+1];
  state_t st_r  [NumRounds+1];
  logic   vld_r [NumRounds+1];
  logic   adv   [NumRounds+1];
  logic   pipe_busy;

  aes128_keyreg u_keyreg (
    .clk     (clk),
    .wr_en   (in_.valid && in_.ready && in_.func == FUNC_LOAD),
    .wr_slot (in_.key_slot),
    .wr_data (in_.data_hi),
    .rkey    (rkey)
  );

  // stage advance: last stage is the output register
  always_comb begin
    adv[NumRounds] = !vld_r[NumRounds] || out_.ready;
    for (int i = NumRounds - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  // any word still in flight
  always_comb begin
    pipe_busy = 1'b0;
    for (int i = 0; i <= NumRounds; i++) begin
      pipe_busy = pipe_busy | vld_r[i];
    end
  end

  // loads only go in on an empty pipeline
  assign in_.ready = adv[0] && (in_.func == FUNC_ENCRYPT || !pipe_busy);

  // stage 0: whitening
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv[0]) begin
      vld_r[0] <= in_.valid && in_.ready && in_.func == FUNC_ENCRYPT;
    end
    if (adv[0]) begin
      st_r[0] <= {in_.data_hi, in_.data_lo} ^ rkey[0];
    end
  end

  // round stages
  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    state_t rnd;
    always_comb begin
      if (g == NumRounds) begin
        rnd = sub_shift(st_r[g-1]) ^ rkey[g];
      end else begin
        rnd = mix_cols(sub_shift(st_r[g-1])) ^ rkey[g];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv[g]) begin
        vld_r[g] <= vld_r[g-1];
      end
      if (adv[g] && vld_r[g-1]) begin
        st_r[g] <= rnd;
      end
    end
  end

  assign out_.valid     = vld_r[NumRounds];
  assign out_.cipher_hi = st_r[NumRounds][127:64];
  assign out_.cipher_lo = st_r[NumRounds][63:0];

  // a stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_.valid && !out_.ready |=> out_.valid && $stable(out_.cipher_hi))
    else $error("result changed under stall");
  // no input taken while the pipe is full and stalled
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && out_.valid && !out_.ready && vld_r[1] && !adv[1] |-> !in_.ready)
    else $error("input accepted into a blocked stage");
  // encrypt word always enters stage 0
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_.valid && in_.ready && in_.func == FUNC_ENCRYPT |=> vld_r[0])
    else $error("encrypt word lost");
  // key writes never land under words in flight
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_.valid && in_.ready && in_.func == FUNC_LOAD |-> !pipe_busy)
    else $error("load accepted with words in flight");

endmodule

/* rtl/aes128_keyreg.sv */
// Round-key store: one 128-bit register per round key, written in 64-bit halves.
// Each round stage reads its own fixed entry. Depends on aes128_pkg.
module aes128_keyreg
  import aes128_pkg::*;
(
  input  logic   clk,
  input  logic   wr_en,
  input  slot_t  wr_slot,
  input  half_t  wr_data,
  output state_t rkey [NumRounds+1]
);

  state_t key_r [NumRounds+1];

  // half-word writes; slots beyond the depth are dropped
  always_ff @(posedge clk) begin
    for (int k = 0; k <= NumRounds; k++) begin
      if (wr_en && wr_slot == slot_t'(2*k)) begin
        key_r[k][127:64] <= wr_data;
      end
      if (wr_en && wr_slot == slot_t'(2*k+1)) begin
        key_r[k][63:0] <= wr_data;
      end
    end
  end

  assign rkey = key_r;

endmodule
